@@ hw/rtl/acwst_pkg.sv @@
`timescale 1ns / 1ps

package acwst_pkg;

    // Timer prescaler divisors
    localparam int SLOW_DIV_DEFAULT = 192;
    localparam int FAST_DIV_DEFAULT = 24;

    // Number of timers
    localparam int NUM_TIMERS = 3;

    // Address decode constants
    localparam logic [15:0] IO_PAGE_MASK  = 16'hFFF0;
    localparam logic [15:0] IO_PAGE_BASE  = 16'h00F0;
    localparam logic [15:0] BOOT_ROM_BASE = 16'hFFC0;

    // Clock costs per wait-state index
    localparam logic [4:0] CPU_COST [4] = '{5'd2, 5'd4, 5'd10, 5'd20};
    localparam logic [4:0] TMR_COST [4] = '{5'd2, 5'd4, 5'd8, 5'd16};

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_EXT_WAIT   = 3'd0,
        CFG_INT_WAIT   = 3'd1,
        CFG_BOOT_ROM   = 3'd2,
        CFG_RUNNING    = 3'd3,
        CFG_ENABLE     = 3'd4,
        CFG_TARGET_0   = 3'd5,
        CFG_TARGET_1   = 3'd6,
        CFG_TARGET_2   = 3'd7
    } t_cfg_idx;

    // Shared step control handed to every timer
    typedef struct packed {
        logic       step;
        logic [4:0] clocks;
        logic       running;
    } t_tmr_step;

endpackage

@@ hw/rtl/acwst_cost.sv @@
`timescale 1ns / 1ps

module acwst_cost
    import acwst_pkg::*;
(
    input  logic        i_has_address,
    input  logic [15:0] i_bus_address,
    input  logic        i_half_cycle,
    input  logic [1:0]  i_ext_sel,
    input  logic [1:0]  i_int_sel,
    input  logic        i_boot_rom,
    output logic [4:0]  o_cpu_clocks,
    output logic [4:0]  o_timer_clocks
);

    logic       use_int;
    logic [1:0] sel;

    // Pick internal setting for idle, I/O page and mapped boot ROM
    always_comb begin
        use_int = !i_has_address
               || ((i_bus_address & IO_PAGE_MASK) == IO_PAGE_BASE)
               || (i_boot_rom && (i_bus_address >= BOOT_ROM_BASE));
        sel     = use_int ? i_int_sel : i_ext_sel;
    end

    // Look up costs, halve on a half cycle
    assign o_cpu_clocks   = CPU_COST[sel] >> i_half_cycle;
    assign o_timer_clocks = TMR_COST[sel] >> i_half_cycle;

endmodule

@@ hw/rtl/acwst_timer.sv @@
`timescale 1ns / 1ps

module acwst_timer
    import acwst_pkg::*;
#(
    parameter int DIVISOR = SLOW_DIV_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_tmr_step  i_step,
    input  logic       i_enable,
    input  logic [7:0] i_target,
    output logic [3:0] o_count_out
);

    localparam logic [8:0] DIV9 = 9'(DIVISOR);

    logic [7:0] r_prescale, n_prescale;
    logic       r_phase,    n_phase;
    logic       r_last,     n_last;
    logic [7:0] r_tick,     n_tick;
    logic [3:0] r_out,      n_out;

    logic [8:0] sum;
    logic       level;

    // Advance prescaler, detect falling edge of gated phase, count ticks
    always_comb begin
        n_prescale = r_prescale;
        n_phase    = r_phase;
        n_last     = r_last;
        n_tick     = r_tick;
        n_out      = r_out;
        sum        = {1'b0, r_prescale} + {4'd0, i_step.clocks};
        level      = !r_phase && i_step.running;
        if (sum < DIV9) begin
            n_prescale = sum[7:0];
        end else begin
            n_prescale = 8'(sum - DIV9);
            n_phase    = !r_phase;
            n_last     = level;
            if (r_last && !level && i_enable) begin
                n_tick = r_tick + 8'd1;
                if (n_tick == i_target) begin
                    n_tick = 8'd0;
                    n_out  = r_out + 4'd1;
                end
            end
        end
    end

    // Hold state unless an item moves to the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prescale <= 8'd0;
            r_phase    <= 1'b0;
            r_last     <= 1'b0;
            r_tick     <= 8'd0;
            r_out      <= 4'd0;
        end else if (i_step.step) begin
            r_prescale <= n_prescale;
            r_phase    <= n_phase;
            r_last     <= n_last;
            r_tick     <= n_tick;
            r_out      <= n_out;
        end
    end

    assign o_count_out = n_out;

endmodule

@@ hw/rtl/audio_cpu_wait_state_and_timers_unit.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Transfer when         | Payload
// s_axis   | in        | tvalid && tready      | bus cycle: has_address, address, half
// m_axis   | out       | tvalid && tready      | clocks and timer output counters
// cfg      | in        | valid && ready        | register index, write data
//
// One item per clock while the result is not stalled; each item passes the input
// register, then cost decode and timer update into the result register.
// Reset (synchronous, active low) clears timers and loads register defaults.
// While the result is stalled one more item is held in the input register;
// the timers advance only when an item moves into the result register.
// Configuration writes are always ready and take effect on the next item.

module audio_cpu_wait_state_and_timers_unit
    import acwst_pkg::*;
#(
    parameter int SLOW_DIVISOR = SLOW_DIV_DEFAULT,
    parameter int FAST_DIVISOR = FAST_DIV_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] has_address, [16:1] bus_address, [17] half_cycle, [23:18] zero
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [4:0] cpu_clocks, [9:5] timer_clocks, [13:10] count_out_zero,
    // [17:14] count_out_one, [21:18] count_out_two, [23:22] zero
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    // Configuration registers
    logic [1:0] r_ext_sel;
    logic [1:0] r_int_sel;
    logic       r_boot_rom;
    logic       r_running;
    logic [2:0] r_enable;
    logic [7:0] r_target [NUM_TIMERS];

    // Pipeline registers
    logic        r_in_valid;
    logic        r_in_has_addr;
    logic [15:0] r_in_addr;
    logic        r_in_half;
    logic        r_out_valid;
    logic [23:0] r_out_data;

    logic        advance;
    logic [4:0]  cpu_clocks;
    logic [4:0]  timer_clocks;
    logic [3:0]  count_out [NUM_TIMERS];
    t_tmr_step   tmr_step;

    assign o_cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_sel   <= 2'd0;
            r_int_sel   <= 2'd0;
            r_boot_rom  <= 1'b1;
            r_running   <= 1'b1;
            r_enable    <= 3'd0;
            r_target[0] <= 8'd0;
            r_target[1] <= 8'd0;
            r_target[2] <= 8'd0;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_EXT_WAIT: r_ext_sel   <= i_cfg_data[1:0];
                CFG_INT_WAIT: r_int_sel   <= i_cfg_data[1:0];
                CFG_BOOT_ROM: r_boot_rom  <= i_cfg_data[0];
                CFG_RUNNING:  r_running   <= i_cfg_data[0];
                CFG_ENABLE:   r_enable    <= i_cfg_data[2:0];
                CFG_TARGET_0: r_target[0] <= i_cfg_data;
                CFG_TARGET_1: r_target[1] <= i_cfg_data;
                CFG_TARGET_2: r_target[2] <= i_cfg_data;
                default:      r_enable    <= r_enable;
            endcase
        end
    end

    // Move an item to the result stage when that stage is free or draining
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // Capture input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_has_addr <= s_axis_tdata[0];
            r_in_addr     <= s_axis_tdata[16:1];
            r_in_half     <= s_axis_tdata[17];
        end
    end

    // Decode wait state and clock costs
    acwst_cost u_cost (
        .i_has_address  (r_in_has_addr),
        .i_bus_address  (r_in_addr),
        .i_half_cycle   (r_in_half),
        .i_ext_sel      (r_ext_sel),
        .i_int_sel      (r_int_sel),
        .i_boot_rom     (r_boot_rom),
        .o_cpu_clocks   (cpu_clocks),
        .o_timer_clocks (timer_clocks)
    );

    assign tmr_step.step    = advance;
    assign tmr_step.clocks  = timer_clocks;
    assign tmr_step.running = r_running;

    // Three timers: two slow, one fast
    acwst_timer #(.DIVISOR(SLOW_DIVISOR)) u_timer0 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (tmr_step),
        .i_enable    (r_enable[0]),
        .i_target    (r_target[0]),
        .o_count_out (count_out[0])
    );

    acwst_timer #(.DIVISOR(SLOW_DIVISOR)) u_timer1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (tmr_step),
        .i_enable    (r_enable[1]),
        .i_target    (r_target[1]),
        .o_count_out (count_out[1])
    );

    acwst_timer #(.DIVISOR(FAST_DIVISOR)) u_timer2 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (tmr_step),
        .i_enable    (r_enable[2]),
        .i_target    (r_target[2]),
        .o_count_out (count_out[2])
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= {2'b00, count_out[2], count_out[1], count_out[0],
                           timer_clocks, cpu_clocks};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule
